/* rtl/owtr_pkg.sv */
// Package for the single-wire temperature reader.
// Holds sequence and slot state types, command bytes and register indexes.
// No dependencies.
package owtr_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 16;
    localparam int IDX_W    = 3;

    typedef logic [REG_W-1:0] t_cfg_reg;
    typedef t_cfg_reg t_cfg_arr [NUM_REGS];

    localparam logic [IDX_W-1:0] REG_RESET_HIGH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RESET_LOW    = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRESENCE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOT_START   = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRITE_HOLD   = 3'd4;
    localparam logic [IDX_W-1:0] REG_WRITE_RECOV  = 3'd5;
    localparam logic [IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [IDX_W-1:0] REG_READ_RECOV   = 3'd7;

    localparam t_cfg_arr CFG_RESET = '{
        16'd10, 16'd600, 16'd500, 16'd1, 16'd60, 16'd60, 16'd10, 16'd20
    };

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_RESET_A = 9'b000000010,
        ST_SKIP_A  = 9'b000000100,
        ST_CONVERT = 9'b000001000,
        ST_RESET_B = 9'b000010000,
        ST_SKIP_B  = 9'b000100000,
        ST_READ_PD = 9'b001000000,
        ST_READ_LO = 9'b010000000,
        ST_READ_HI = 9'b100000000
    } t_step;

    typedef enum logic [2:0] {
        PH_OPEN  = 3'b001,
        PH_MID   = 3'b010,
        PH_CLOSE = 3'b100
    } t_phase;

endpackage

/* rtl/one_wire_temp_sensor_reader_top.sv */
// Top level of the single-wire temperature reader.
// Uses owtr_pkg for state types, command bytes and register indexes.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus tick per request:
//   i_start_req and the sampled line level i_bus_level. Each accepted request
//   yields exactly one result request on the output channel (o_out_valid /
//   i_out_ready): o_drive_low, o_busy_res, o_done_res, o_raw_reading and
//   o_temperature_tenths for that tick.
//   Results are registered and valid the cycle after acceptance; throughput is
//   one request per cycle unless stalled, set by the single result register.
//   A start taken while idle runs reset, skip-ROM, convert, reset, skip-ROM,
//   read-scratchpad and two read bytes; every phase lasts max(register,1)
//   ticks. o_done_res marks the tick that ends the last read slot.
//   When the receiver stalls with a result pending, o_in_ready drops and the
//   sequencer holds; a result being taken frees the register the same cycle.
//   Synchronous reset clears the sequencer, the reading and the output valid,
//   and loads the timing registers with their defaults.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once
//   and are meant for idle periods only.
module one_wire_temp_sensor_reader_top #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [owtr_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [owtr_pkg::REG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_start_req,
    input  logic                            i_bus_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_drive_low,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [15:0]                     o_raw_reading,
    output logic [15:0]                     o_temperature_tenths
);

    localparam int CW = (COUNTER_BITS > owtr_pkg::REG_W) ? COUNTER_BITS : owtr_pkg::REG_W;

    owtr_pkg::t_cfg_arr        r_cfg;
    owtr_pkg::t_step           r_step, n_step;
    owtr_pkg::t_phase          r_phase, n_phase;
    logic [COUNTER_BITS-1:0]   r_tick, n_tick;
    logic [2:0]                r_bit, n_bit;
    logic [7:0]                r_shift, n_shift;
    logic [7:0]                r_low, n_low;
    logic [15:0]               r_last, n_last;

    logic                      r_out_valid;
    logic                      r_drive, n_drive;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [15:0]               r_raw;
    logic [15:0]               r_tenths, n_tenths;

    owtr_pkg::t_step           c_step;
    owtr_pkg::t_phase          c_phase;
    logic [COUNTER_BITS-1:0]   c_tick;
    logic [2:0]                c_bit;
    logic [7:0]                c_shift;
    logic                      w_accept;
    logic                      w_is_reset;
    logic                      w_is_read;
    logic [7:0]                w_cmd;
    logic [owtr_pkg::REG_W-1:0] w_reg, w_len;
    logic [CW:0]               w_tick_inc, w_len_ext;
    logic                      w_phase_end;
    logic [18:0]               w_times5;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Normalize the current state and take a start request.
    always_comb begin
        c_step  = r_step;
        c_phase = r_phase;
        c_tick  = r_tick;
        c_bit   = r_bit;
        c_shift = r_shift;
        unique case (r_step)
            owtr_pkg::ST_IDLE, owtr_pkg::ST_RESET_A, owtr_pkg::ST_SKIP_A,
            owtr_pkg::ST_CONVERT, owtr_pkg::ST_RESET_B, owtr_pkg::ST_SKIP_B,
            owtr_pkg::ST_READ_PD, owtr_pkg::ST_READ_LO, owtr_pkg::ST_READ_HI: begin
            end
            default: begin
                c_step  = owtr_pkg::ST_IDLE;
                c_phase = owtr_pkg::PH_OPEN;
                c_tick  = '0;
            end
        endcase
        if (c_step == owtr_pkg::ST_IDLE && i_start_req) begin
            c_step  = owtr_pkg::ST_RESET_A;
            c_phase = owtr_pkg::PH_OPEN;
            c_tick  = '0;
            c_bit   = '0;
            c_shift = '0;
        end
    end

    assign w_is_reset = (c_step == owtr_pkg::ST_RESET_A) || (c_step == owtr_pkg::ST_RESET_B);
    assign w_is_read  = (c_step == owtr_pkg::ST_READ_LO) || (c_step == owtr_pkg::ST_READ_HI);

    always_comb begin
        priority if (c_step == owtr_pkg::ST_CONVERT) begin
            w_cmd = owtr_pkg::CMD_CONVERT;
        end else if (c_step == owtr_pkg::ST_READ_PD) begin
            w_cmd = owtr_pkg::CMD_READ_PAD;
        end else begin
            w_cmd = owtr_pkg::CMD_SKIP_ROM;
        end
    end

    always_comb begin
        unique case (c_phase)
            owtr_pkg::PH_OPEN:
                w_reg = w_is_reset ? r_cfg[owtr_pkg::REG_RESET_HIGH]
                                   : r_cfg[owtr_pkg::REG_SLOT_START];
            owtr_pkg::PH_MID:
                w_reg = w_is_reset ? r_cfg[owtr_pkg::REG_RESET_LOW]
                      : w_is_read  ? r_cfg[owtr_pkg::REG_READ_SAMPLE]
                                   : r_cfg[owtr_pkg::REG_WRITE_HOLD];
            owtr_pkg::PH_CLOSE:
                w_reg = w_is_reset ? r_cfg[owtr_pkg::REG_PRESENCE]
                      : w_is_read  ? r_cfg[owtr_pkg::REG_READ_RECOV]
                                   : r_cfg[owtr_pkg::REG_WRITE_RECOV];
            default:
                w_reg = '0;
        endcase
    end

    assign w_len      = (w_reg == '0) ? {{(owtr_pkg::REG_W - 1){1'b0}}, 1'b1} : w_reg;
    assign w_tick_inc = {{(CW + 1 - COUNTER_BITS){1'b0}}, c_tick} + (CW + 1)'(1);
    assign w_len_ext  = {{(CW + 1 - owtr_pkg::REG_W){1'b0}}, w_len};

    always_comb begin
        n_step  = c_step;
        n_phase = c_phase;
        n_tick  = c_tick;
        n_bit   = c_bit;
        n_shift = c_shift;
        n_low   = r_low;
        n_last  = r_last;
        n_drive = 1'b0;
        n_busy  = 1'b0;
        n_done  = 1'b0;
        w_phase_end = 1'b0;
        if (c_step != owtr_pkg::ST_IDLE) begin
            n_busy = 1'b1;
            unique case (c_phase)
                owtr_pkg::PH_OPEN:  n_drive = !w_is_reset;
                owtr_pkg::PH_MID:   n_drive = w_is_reset || (!w_is_read && !w_cmd[c_bit]);
                owtr_pkg::PH_CLOSE: n_drive = 1'b0;
                default:            n_drive = 1'b0;
            endcase
            unique case (c_phase)
                owtr_pkg::PH_OPEN, owtr_pkg::PH_MID, owtr_pkg::PH_CLOSE:
                    w_phase_end = (w_tick_inc >= w_len_ext) || (c_tick == '1);
                default: begin
                    w_phase_end = 1'b1;
                    n_drive     = 1'b0;
                    n_phase     = owtr_pkg::PH_CLOSE;
                end
            endcase
            if (!w_phase_end) begin
                n_tick = c_tick + COUNTER_BITS'(1);
            end else begin
                n_tick = '0;
                if (w_is_read && c_phase == owtr_pkg::PH_MID) begin
                    n_shift = {i_bus_level, c_shift[7:1]};
                end
                unique case (n_phase)
                    owtr_pkg::PH_OPEN: n_phase = owtr_pkg::PH_MID;
                    owtr_pkg::PH_MID:  n_phase = owtr_pkg::PH_CLOSE;
                    default: begin
                        n_phase = owtr_pkg::PH_OPEN;
                        if (w_is_reset) begin
                            n_step = (c_step == owtr_pkg::ST_RESET_A) ? owtr_pkg::ST_SKIP_A
                                                                      : owtr_pkg::ST_SKIP_B;
                        end else begin
                            n_bit = c_bit + 3'd1;
                            if (c_bit == 3'd7) begin
                                unique case (c_step)
                                    owtr_pkg::ST_SKIP_A:  n_step = owtr_pkg::ST_CONVERT;
                                    owtr_pkg::ST_CONVERT: n_step = owtr_pkg::ST_RESET_B;
                                    owtr_pkg::ST_SKIP_B:  n_step = owtr_pkg::ST_READ_PD;
                                    owtr_pkg::ST_READ_PD: n_step = owtr_pkg::ST_READ_LO;
                                    owtr_pkg::ST_READ_LO: begin
                                        n_low  = n_shift;
                                        n_step = owtr_pkg::ST_READ_HI;
                                    end
                                    owtr_pkg::ST_READ_HI: begin
                                        n_last = {n_shift, r_low};
                                        n_done = 1'b1;
                                        n_step = owtr_pkg::ST_IDLE;
                                    end
                                    default: n_step = owtr_pkg::ST_IDLE;
                                endcase
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign w_times5 = {1'b0, n_last, 2'b00} + {3'b000, n_last} + 19'd4;
    assign n_tenths = w_times5[18:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= owtr_pkg::CFG_RESET;
            r_step      <= owtr_pkg::ST_IDLE;
            r_phase     <= owtr_pkg::PH_OPEN;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_low       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (w_accept) begin
                r_step  <= n_step;
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_low   <= n_low;
                r_last  <= n_last;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_drive  <= n_drive;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_raw    <= n_last;
            r_tenths <= n_tenths;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_drive_low          = r_drive;
    assign o_busy_res           = r_busy;
    assign o_done_res           = r_done;
    assign o_raw_reading        = r_raw;
    assign o_temperature_tenths = r_tenths;

endmodule

/* rtl/owtr_checker.sv */
// Port-level checker for the single-wire temperature reader, bound to the top level.
// Connects to the top-level ports by name; no package dependencies.
module owtr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_drive_low,
    input logic                        o_busy_res,
    input logic                        o_done_res,
    input logic [15:0]                 o_raw_reading,
    input logic [15:0]                 o_temperature_tenths
);

    logic [18:0] w_expect;

    assign w_expect = ({3'b000, o_raw_reading} * 19'd5) + 19'd4;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_low |-> o_busy_res)
        else $error("line driven while idle");

    a_tenths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_temperature_tenths == w_expect[18:3])
        else $error("temperature does not match raw reading");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request accepted while result stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_raw_reading))
        else $error("stalled result changed");

endmodule

bind one_wire_temp_sensor_reader_top owtr_checker u_owtr_checker (.*);
